### design/mip_chain_size_calculator_top_defines.svh
// Assertion macros shared by the mip chain size calculator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIP_CHAIN_SIZE_CALCULATOR_TOP_DEFINES_SVH
`define MIP_CHAIN_SIZE_CALCULATOR_TOP_DEFINES_SVH
// Assert an implication on every clock edge outside reset.
`define MCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert an implication in the next cycle.
`define MCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### design/mcs_pkg.sv
// Package for the mip chain size calculator: widths, state type, pipeline token.
// No dependencies.
`default_nettype none
package mcs_pkg;
	localparam int DIM_BITS   = 16;
	localparam int MAX_LEVELS = 31;
	localparam int LVL_BITS   = 5;
	localparam int SUM_BITS   = 64;
	localparam int BASE_BITS  = 21; // bytes_per_texel * slice_count

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_OUT} state_t;

	// token handed from stage to stage of the multiply pipeline: one level in flight
	typedef struct packed {
		logic                vld;
		logic [LVL_BITS-1:0] lvl;
	} tok_t;
endpackage
`default_nettype wire

### design/mcs_cell.sv
// One cell of the level chain: halves its dimension with round-up each cycle it is not loaded.
// Depends on mcs_pkg.
`default_nettype none
module mcs_cell import mcs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic [DIM_BITS-1:0] dim_in,
	output logic      [DIM_BITS-1:0] dim_q
);
	// hold current level's dimension; advance = ceil(dim/2)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= '0;
		end else if (load) begin
			dim_q <= dim_in;
		end else begin
			dim_q <= DIM_BITS'(({1'b0, dim_q} + 1'b1) >> 1);
		end
	end
endmodule
`default_nettype wire

### design/mip_chain_size_calculator_top.sv
// Top level of the mip chain size calculator: stream ports, control, adder.
// Depends on mcs_pkg, mcs_cell and the assertion macro header.
//
// One item at a time. After acceptance, three dimension cells (width, height,
// depth) step one mip level per cycle, each rounding its dimension up as it
// halves it, so level k holds ceil(dim / 2^k). Each level size goes through
// a two-stage multiply pipeline (w*h and base*d, then the two products) and
// into a 64-bit accumulator. Once the last level has left the pipeline, the
// result waits in an output register, and a new transaction is taken in the
// cycle after that register has been emptied.
`default_nettype none
`include "mip_chain_size_calculator_top_defines.svh"
module mip_chain_size_calculator_top import mcs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// width[15:0], height[31:16], depth[47:32], slice_count[63:48],
	// bytes_per_texel[68:64], levels_wanted[73:69], zero pad [79:74]
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// total_bytes[63:0], full_mip_count[68:64], zero pad [71:69]
	output logic      [71:0] m_tdata
);
	state_t state_q, state_d;
	logic   acc_in;
	logic   [LVL_BITS-1:0] lvl_q;      // levels remaining to issue
	logic   [BASE_BITS-1:0] base_q;    // bytes per texel times slices
	logic   [SUM_BITS-1:0] total_q;
	logic   [LVL_BITS-1:0] fmc_q;
	logic   [DIM_BITS-1:0] w_q, h_q, d_q;
	logic   [2*DIM_BITS-1:0] wh_s1;
	logic   [BASE_BITS+DIM_BITS-1:0] bd_s1;
	logic   [SUM_BITS-1:0] size_s2;
	tok_t   tok_s1, tok_s2;
	logic   [DIM_BITS-1:0] in_w, in_h, in_d, largest;
	logic   [LVL_BITS-1:0] in_lv, fmc;

	assign in_w  = s_tdata[15:0];
	assign in_h  = s_tdata[31:16];
	assign in_d  = s_tdata[47:32];
	assign in_lv = s_tdata[73:69];
	assign acc_in = s_tvalid && s_tready;

	// full mip count from the largest dimension
	always_comb begin
		largest = in_w;
		if (in_h > largest) largest = in_h;
		if (in_d > largest) largest = in_d;
		fmc = LVL_BITS'(1);
		for (int i = DIM_BITS; i >= 1; i--) begin
			if ({1'b0, largest} > ((DIM_BITS+1)'(1) << (i - 1))) begin
				fmc = LVL_BITS'(i + 1);
				break;
			end
		end
	end

	mcs_cell u_cw (.clk, .arst_n, .load(acc_in), .dim_in(in_w), .dim_q(w_q));
	mcs_cell u_ch (.clk, .arst_n, .load(acc_in), .dim_in(in_h), .dim_q(h_q));
	mcs_cell u_cd (.clk, .arst_n, .load(acc_in), .dim_in(in_d), .dim_q(d_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
			tok_s1  <= '0;
			tok_s2  <= '0;
		end else begin
			state_q <= state_d;
			if (acc_in) begin
				lvl_q <= in_lv;
			end else if (state_q == ST_RUN && lvl_q != '0) begin
				lvl_q <= lvl_q - 1'b1;
			end
			tok_s1.vld <= (state_q == ST_RUN) && (lvl_q != '0);
			tok_s1.lvl <= lvl_q;
			tok_s2     <= tok_s1;
		end
	end

	// payload: multiply pipeline and accumulator
	always_ff @(posedge clk) begin
		if (acc_in) begin
			base_q  <= BASE_BITS'(s_tdata[68:64] * s_tdata[63:48]);
			fmc_q   <= fmc;
			total_q <= '0;
		end else if (tok_s2.vld) begin
			total_q <= total_q + size_s2;
		end
		wh_s1   <= w_q * h_q;
		bd_s1   <= base_q * d_q;
		size_s2 <= SUM_BITS'(wh_s1 * bd_s1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (acc_in) state_d = ST_RUN;
			ST_RUN:   if (lvl_q == '0 || lvl_q == LVL_BITS'(1)) state_d = ST_DRAIN;
			ST_DRAIN: if (!tok_s1.vld && !tok_s2.vld) state_d = ST_OUT;
			ST_OUT:   if (m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {3'b000, fmc_q, total_q};

	`MCS_ASSERT_IMP(a_excl, clk, arst_n, m_tvalid, !s_tready, "both sides active")
	`MCS_ASSERT_IMP(a_drain, clk, arst_n, m_tvalid, !tok_s1.vld && !tok_s2.vld,
		"result shown with level in flight")
	`MCS_ASSERT_NEXT(a_load, clk, arst_n, acc_in, state_q == ST_RUN, "no start after accept")
	`MCS_ASSERT_IMP(a_idle, clk, arst_n, s_tready, !tok_s1.vld, "token while idle")
endmodule
`default_nettype wire
